// ===== rtl/core/gated_sample_recorder_write_head_defines.svh =====
// ----------------------------------------------------------------------------
// gated sample recorder write head: assertion macros
// shared check macros, clocked on the rising edge, quiet while reset is high
// ----------------------------------------------------------------------------
`ifndef GATED_SAMPLE_RECORDER_WRITE_HEAD_DEFINES_SVH
`define GATED_SAMPLE_RECORDER_WRITE_HEAD_DEFINES_SVH

// consequence must hold in the same cycle as the antecedent
`define GSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence must hold in the cycle after the antecedent
`define GSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/gsr_pkg.sv =====
// ----------------------------------------------------------------------------
// gsr_pkg
// types and constants shared by the recorder write head modules
// ----------------------------------------------------------------------------
package gsr_pkg;

   localparam int ADDR_BITS   = 16;
   localparam int CHANNELS    = 4;
   localparam int SAMPLE_BITS = 32;
   localparam int GATE_BITS   = 16;
   localparam int LEN_BITS    = 17;
   localparam int CSR_IDX_BITS = 3;

   // one past the last table address
   localparam logic [LEN_BITS-1:0] ADDR_SPAN = LEN_BITS'(1) << ADDR_BITS;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_REC    = 2'd1,
      FUNC_STOP   = 2'd2,
      FUNC_RSVD   = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CONTINUE_MODE = 3'd0,
      CSR_LOOP_MODE     = 3'd1,
      CSR_INDEXED_MODE  = 3'd2,
      CSR_WHOLE_TABLE   = 3'd3,
      CSR_START_INDEX   = 3'd4,
      CSR_END_INDEX     = 3'd5,
      CSR_TABLE_LENGTH  = 3'd6,
      CSR_TABLE_READY   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]             func;
      logic [GATE_BITS-1:0]   gate_or_index;
      logic [SAMPLE_BITS-1:0] sample_ch0;
      logic [SAMPLE_BITS-1:0] sample_ch1;
      logic [SAMPLE_BITS-1:0] sample_ch2;
      logic [SAMPLE_BITS-1:0] sample_ch3;
   } gsr_req_type;

   typedef struct packed {
      logic                   write_enable;
      logic [ADDR_BITS-1:0]   write_address;
      logic [SAMPLE_BITS-1:0] data_ch0;
      logic [SAMPLE_BITS-1:0] data_ch1;
      logic [SAMPLE_BITS-1:0] data_ch2;
      logic [SAMPLE_BITS-1:0] data_ch3;
      logic [ADDR_BITS-1:0]   head_position;
      logic                   range_done;
   } gsr_rsp_type;

   // per-item decision from the head controller
   typedef struct packed {
      logic                 write_enable;
      logic [ADDR_BITS-1:0] write_address;
      logic [ADDR_BITS-1:0] head_position;
      logic                 range_done;
   } gsr_ctl_type;

   // load strobes for the two-entry output buffer
   typedef struct packed {
      logic main_load_new;
      logic main_from_skid;
      logic skid_load;
   } gsr_buf_ctl_type;

endpackage

// ===== rtl/core/gsr_lane.sv =====
// ----------------------------------------------------------------------------
// gsr_lane
// one channel lane: gates the sample word by the write decision and holds it
// in the two-entry output buffer
// ----------------------------------------------------------------------------
module gsr_lane (
   input  logic                             clock,
   input  logic [gsr_pkg::SAMPLE_BITS-1:0]  sample_in,
   input  logic                             write_en,
   input  gsr_pkg::gsr_buf_ctl_type         buf_ctl,
   output logic [gsr_pkg::SAMPLE_BITS-1:0]  data_out
);
   import gsr_pkg::*;

   logic [SAMPLE_BITS-1:0] main_ff, main_in;
   logic [SAMPLE_BITS-1:0] skid_ff, skid_in;
   logic [SAMPLE_BITS-1:0] gated;

   // no write means a zero data word
   assign gated = write_en ? sample_in : '0;

   always_comb begin
      main_in = main_ff;
      skid_in = skid_ff;
      if (buf_ctl.main_from_skid) begin
         main_in = skid_ff;
      end else if (buf_ctl.main_load_new) begin
         main_in = gated;
      end
      if (buf_ctl.skid_load) begin
         skid_in = gated;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign data_out = main_ff;

endmodule

// ===== rtl/core/gsr_head.sv =====
// ----------------------------------------------------------------------------
// gsr_head
// control registers and write-head state: gate edge detection, range check,
// head advance with wrap or stop, indexed address check
// ----------------------------------------------------------------------------
module gsr_head (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [gsr_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [gsr_pkg::LEN_BITS-1:0]      csr_wdata,
   input  logic                              fire,
   input  logic [1:0]                        func,
   input  logic [gsr_pkg::GATE_BITS-1:0]     gate_or_index,
   output gsr_pkg::gsr_ctl_type              ctl
);
   import gsr_pkg::*;

   // configuration
   logic                continue_mode_ff, loop_mode_ff, indexed_mode_ff;
   logic                whole_table_ff, table_ready_ff;
   logic [15:0]         start_index_ff;
   logic [LEN_BITS-1:0] end_index_ff, table_length_ff;

   // head state
   logic                gate_was_on_ff, gate_was_on_in;
   logic                recording_ff, recording_in;
   logic                fresh_run_ff, fresh_run_in;
   logic [LEN_BITS-1:0] head_ff, head_in;
   logic [ADDR_BITS-1:0] shown_ff, shown_in;

   logic [LEN_BITS-1:0] npts, range_end, start_ext, gi_ext, ph;
   logic                range_ok, gate, rec_t, stop_t, active;
   func_type            func_e;

   assign func_e    = func_type'(func);
   assign start_ext = {1'b0, start_index_ff};
   assign gi_ext    = {1'b0, gate_or_index};
   assign npts      = (table_length_ff > ADDR_SPAN) ? ADDR_SPAN : table_length_ff;
   assign range_end = whole_table_ff ? npts
                    : ((end_index_ff < npts) ? end_index_ff : npts);
   assign range_ok  = start_ext < range_end;
   assign gate      = |gate_or_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         continue_mode_ff <= 1'b0;
         loop_mode_ff     <= 1'b0;
         indexed_mode_ff  <= 1'b0;
         whole_table_ff   <= 1'b1;
         start_index_ff   <= '0;
         end_index_ff     <= '0;
         table_length_ff  <= ADDR_SPAN;
         table_ready_ff   <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CONTINUE_MODE: continue_mode_ff <= csr_wdata[0];
            CSR_LOOP_MODE:     loop_mode_ff     <= csr_wdata[0];
            CSR_INDEXED_MODE:  indexed_mode_ff  <= csr_wdata[0];
            CSR_WHOLE_TABLE:   whole_table_ff   <= csr_wdata[0];
            CSR_START_INDEX:   start_index_ff   <= csr_wdata[15:0];
            CSR_END_INDEX:     end_index_ff     <= csr_wdata;
            CSR_TABLE_LENGTH:  table_length_ff  <= csr_wdata;
            CSR_TABLE_READY:   table_ready_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      gate_was_on_in = gate_was_on_ff;
      recording_in   = recording_ff;
      fresh_run_in   = fresh_run_ff;
      head_in        = head_ff;
      shown_in       = shown_ff;
      rec_t          = 1'b0;
      stop_t         = 1'b0;
      active         = 1'b0;
      ph             = head_ff;
      ctl            = '0;

      case (func_e)
         FUNC_REC: begin
            if (table_ready_ff) begin
               recording_in = 1'b1;
               fresh_run_in = 1'b1;
               if (!continue_mode_ff) head_in = '0;
            end
         end
         FUNC_STOP: begin
            if (table_ready_ff) begin
               recording_in = 1'b0;
               if (!continue_mode_ff) head_in = '0;
            end
         end
         FUNC_SAMPLE: begin
            if (indexed_mode_ff) begin
               if (range_ok && table_ready_ff && gi_ext >= start_ext
                   && gi_ext < range_end) begin
                  ctl.write_enable  = 1'b1;
                  ctl.write_address = gate_or_index[ADDR_BITS-1:0];
               end
            end else begin
               // gate edges act as rec and stop commands
               rec_t  = table_ready_ff && gate && !gate_was_on_ff;
               stop_t = table_ready_ff && !gate && gate_was_on_ff;
               gate_was_on_in = gate;
               if ((rec_t || stop_t) && !continue_mode_ff) head_in = '0;
               if (rec_t) begin
                  recording_in = 1'b1;
                  fresh_run_in = 1'b1;
               end else if (stop_t) begin
                  recording_in = 1'b0;
               end
               active = range_ok && table_ready_ff && recording_in;
               if (active) begin
                  if (fresh_run_in && !continue_mode_ff) begin
                     fresh_run_in = 1'b0;
                     head_in      = start_ext;
                  end
                  ph = head_in;
                  if (ph >= range_end) begin
                     ctl.range_done = 1'b1;
                     if (loop_mode_ff) ph = start_ext;
                     else recording_in = 1'b0;
                  end
                  if (ph < start_ext) ph = start_ext;
                  if (recording_in) begin
                     ctl.write_enable  = 1'b1;
                     ctl.write_address = ph[ADDR_BITS-1:0];
                     shown_in          = ph[ADDR_BITS-1:0];
                     head_in           = ph + LEN_BITS'(1);
                  end
               end
               ctl.head_position = shown_in;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_was_on_ff <= 1'b0;
         recording_ff   <= 1'b0;
         fresh_run_ff   <= 1'b0;
         head_ff        <= '0;
         shown_ff       <= '0;
      end else if (fire) begin
         gate_was_on_ff <= gate_was_on_in;
         recording_ff   <= recording_in;
         fresh_run_ff   <= fresh_run_in;
         head_ff        <= head_in;
         shown_ff       <= shown_in;
      end
   end

endmodule

// ===== rtl/core/gated_sample_recorder_write_head.sv =====
// ----------------------------------------------------------------------------
// gated_sample_recorder_write_head
// write-head controller of a four channel sample recorder
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one beat per item: a sample (gate level or index plus one
//   word per channel) or a rec / stop command. commands change the head
//   state and return no beat. every sample returns one write command beat on
//   rsp_* with the head position and the range-end flag.
//   csr_* writes one control register per cycle; the user must keep the block idle (not enforced).
// path and throughput:
//   a sample beat is registered in the output register, or in the skid entry while a result waits,
//   before it shows on rsp_*. one item is taken every cycle while req_ready is high; the head
//   update for an item settles in the cycle it is accepted, so back-to-back items see the previous head.
// stall behavior:
//   a two-entry output buffer (output register plus skid) lets one more item
//   in while a result waits; req_ready drops only when both entries are full.
// reset:
//   synchronous, active high. registers return to their defaults (whole
//   table on, length 65536, table not ready), head state clears, buffer
//   empties.
// ----------------------------------------------------------------------------
`include "gated_sample_recorder_write_head_defines.svh"

module gated_sample_recorder_write_head (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  gsr_pkg::gsr_req_type              req_beat,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output gsr_pkg::gsr_rsp_type              rsp_beat,
   input  logic                              csr_write_en,
   input  logic [gsr_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [gsr_pkg::LEN_BITS-1:0]      csr_wdata
);
   import gsr_pkg::*;

   logic            fire, push, pop;
   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   gsr_ctl_type     ctl;
   gsr_ctl_type     ctl_main_ff, ctl_main_in, ctl_skid_ff, ctl_skid_in;
   gsr_buf_ctl_type buf_ctl;

   logic [CHANNELS-1:0][SAMPLE_BITS-1:0] lane_sample;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0] lane_data;

   assign req_ready = !skid_valid_ff;
   assign fire      = req_valid && req_ready;
   assign push      = fire && (func_type'(req_beat.func) == FUNC_SAMPLE);
   assign pop       = rsp_valid && rsp_ready;

   gsr_head u_head (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fire          (fire),
      .func          (req_beat.func),
      .gate_or_index (req_beat.gate_or_index),
      .ctl           (ctl)
   );

   // output buffer control
   always_comb begin
      buf_ctl.main_load_new  = push && (!main_valid_ff || pop);
      buf_ctl.main_from_skid = pop && skid_valid_ff;
      buf_ctl.skid_load      = push && main_valid_ff && !pop;
      main_valid_in = main_valid_ff ? (pop ? (skid_valid_ff || push) : 1'b1) : push;
      skid_valid_in = skid_valid_ff ? !pop : buf_ctl.skid_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_comb begin
      ctl_main_in = ctl_main_ff;
      ctl_skid_in = ctl_skid_ff;
      if (buf_ctl.main_from_skid) begin
         ctl_main_in = ctl_skid_ff;
      end else if (buf_ctl.main_load_new) begin
         ctl_main_in = ctl;
      end
      if (buf_ctl.skid_load) begin
         ctl_skid_in = ctl;
      end
   end

   always_ff @(posedge clock) begin
      ctl_main_ff <= ctl_main_in;
      ctl_skid_ff <= ctl_skid_in;
   end

   // channel lanes
   assign lane_sample[0] = req_beat.sample_ch0;
   assign lane_sample[1] = req_beat.sample_ch1;
   assign lane_sample[2] = req_beat.sample_ch2;
   assign lane_sample[3] = req_beat.sample_ch3;

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      gsr_lane u_lane (
         .clock     (clock),
         .sample_in (lane_sample[g]),
         .write_en  (ctl.write_enable),
         .buf_ctl   (buf_ctl),
         .data_out  (lane_data[g])
      );
   end

   // merge lanes with the head decision
   assign rsp_valid = main_valid_ff;
   always_comb begin
      rsp_beat.write_enable  = ctl_main_ff.write_enable;
      rsp_beat.write_address = ctl_main_ff.write_address;
      rsp_beat.data_ch0      = lane_data[0];
      rsp_beat.data_ch1      = lane_data[1];
      rsp_beat.data_ch2      = lane_data[2];
      rsp_beat.data_ch3      = lane_data[3];
      rsp_beat.head_position = ctl_main_ff.head_position;
      rsp_beat.range_done    = ctl_main_ff.range_done;
   end

   `GSR_ASSERT_NOW(a_skid_needs_main, clock, reset, skid_valid_ff, main_valid_ff,
      "skid entry held without an output entry")
   `GSR_ASSERT_NEXT(a_skid_catch, clock, reset, push && main_valid_ff && !pop,
      skid_valid_ff, "beat arriving behind a stalled result was not caught")
   `GSR_ASSERT_NOW(a_no_write_zero, clock, reset, rsp_valid && !rsp_beat.write_enable,
      rsp_beat.write_address == '0 && rsp_beat.data_ch0 == '0 && rsp_beat.data_ch3 == '0,
      "result without write carries nonzero address or data")

endmodule
